// ===== hw/rtl/bmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpd_pkg
// shared types and constants for the 24-bit bmp pixel stream decoder
// ----------------------------------------------------------------------------
package bmpd_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;
    localparam int unsigned DIM_W      = 13;

    localparam logic [31:0] HEADER_END = 32'd26;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    localparam logic [31:0] POS_SIG0        = 32'd0;
    localparam logic [31:0] POS_SIG1        = 32'd1;
    localparam logic [31:0] POS_OFS_FIRST   = 32'd10;
    localparam logic [31:0] POS_OFS_LAST    = 32'd13;
    localparam logic [31:0] POS_DIM_FIRST   = 32'd18;
    localparam logic [31:0] POS_WIDTH_LAST  = 32'd21;
    localparam logic [31:0] POS_HEIGHT_LAST = 32'd25;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SIG = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [2:0] CFG_RGBA_MODE  = 3'd0;
    localparam logic [2:0] CFG_KEY_ENABLE = 3'd1;
    localparam logic [2:0] CFG_KEY_RED    = 3'd2;
    localparam logic [2:0] CFG_KEY_GREEN  = 3'd3;
    localparam logic [2:0] CFG_KEY_BLUE   = 3'd4;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_PIXEL  = 5'b00100,
        PH_PAD    = 5'b01000,
        PH_IDLE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       rgba_mode;
        logic       key_enable;
        logic [7:0] key_red;
        logic [7:0] key_green;
        logic [7:0] key_blue;
    } key_cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_pixel;
        logic [1:0] status;
    } pix_result_t;

endpackage

// ===== hw/rtl/bmpd_parser.sv =====
// ----------------------------------------------------------------------------
// bmpd_parser
// header parse, offset skip, pixel assembly and row padding state
// ----------------------------------------------------------------------------
module bmpd_parser
    import bmpd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = bmpd_pkg::MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              start_of_file,
    input  key_cfg_t          cfg,
    output pix_result_t       res
);

    phase_t             phase_reg,  phase_next,  cur_phase;
    logic [31:0]        pos_reg,    pos_next,    cur_pos;
    logic [31:0]        asm_reg,    asm_next,    cur_asm;
    logic [31:0]        start_reg,  start_next,  cur_start;
    logic [DIM_W-1:0]   width_reg,  width_next,  cur_width;
    logic [DIM_W-1:0]   height_reg, height_next, cur_height;
    logic [1:0]         chan_reg,   chan_next,   cur_chan;
    logic [7:0]         blue_reg,   blue_next,   cur_blue;
    logic [7:0]         green_reg,  green_next,  cur_green;
    logic [DIM_W-1:0]   col_reg,    col_next,    cur_col;
    logic [DIM_W-1:0]   row_reg,    row_next,    cur_row;
    logic [1:0]         pad_reg,    pad_next,    cur_pad;

    logic [1:0]         asm_k;
    logic [31:0]        asm_merged;
    logic               in_field;
    logic               last_col;
    logic               last_row;
    logic               key_hit;
    logic [1:0]         pad_dec;
    logic               skip_done;

    // a new file drops all parse state before the byte is taken
    assign cur_phase  = start_of_file ? PH_HEADER : phase_reg;
    assign cur_pos    = start_of_file ? '0 : pos_reg;
    assign cur_asm    = start_of_file ? '0 : asm_reg;
    assign cur_start  = start_of_file ? '0 : start_reg;
    assign cur_width  = start_of_file ? '0 : width_reg;
    assign cur_height = start_of_file ? '0 : height_reg;
    assign cur_chan   = start_of_file ? '0 : chan_reg;
    assign cur_blue   = start_of_file ? '0 : blue_reg;
    assign cur_green  = start_of_file ? '0 : green_reg;
    assign cur_col    = start_of_file ? '0 : col_reg;
    assign cur_row    = start_of_file ? '0 : row_reg;
    assign cur_pad    = start_of_file ? '0 : pad_reg;

    assign asm_k    = cur_pos[1:0] - 2'd2;
    assign in_field = ((cur_pos >= POS_OFS_FIRST) && (cur_pos <= POS_OFS_LAST)) ||
                      ((cur_pos >= POS_DIM_FIRST) && (cur_pos <= POS_HEIGHT_LAST));

    always_comb
    begin
        case (asm_k)
            2'd0:    asm_merged = {24'h000000, data_byte};
            default: asm_merged = cur_asm | ({24'h000000, data_byte} << {asm_k, 3'b000});
        endcase
    end

    assign last_col  = ({1'b0, cur_col} + 14'd1) >= {1'b0, cur_width};
    assign last_row  = ({1'b0, cur_row} + 14'd1) >= {1'b0, cur_height};
    assign key_hit   = cfg.rgba_mode && cfg.key_enable && (data_byte == cfg.key_red) &&
                       (cur_green == cfg.key_green) && (cur_blue == cfg.key_blue);
    assign pad_dec   = cur_pad - 2'd1;
    assign skip_done = ({1'b0, cur_pos} + 33'd1) >= {1'b0, cur_start};

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        asm_next    = asm_reg;
        start_next  = start_reg;
        width_next  = width_reg;
        height_next = height_reg;
        chan_next   = chan_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pad_next    = pad_reg;
        res         = '0;

        if (step)
        begin
            phase_next  = cur_phase;
            pos_next    = cur_pos;
            asm_next    = cur_asm;
            start_next  = cur_start;
            width_next  = cur_width;
            height_next = cur_height;
            chan_next   = cur_chan;
            blue_next   = cur_blue;
            green_next  = cur_green;
            col_next    = cur_col;
            row_next    = cur_row;
            pad_next    = cur_pad;

            unique case (cur_phase)
                PH_HEADER:
                begin
                    if (((cur_pos == POS_SIG0) && (data_byte != SIG_B)) ||
                        ((cur_pos == POS_SIG1) && (data_byte != SIG_M)))
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_BAD_SIG;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        pos_next = cur_pos + 32'd1;
                        if (in_field)
                        begin
                            asm_next = asm_merged;
                        end
                        if (cur_pos == POS_OFS_LAST)
                        begin
                            if (asm_merged < HEADER_END)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_RANGE;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                start_next = asm_merged;
                            end
                        end
                        else if (cur_pos == POS_WIDTH_LAST)
                        begin
                            if ((asm_merged == '0) || (asm_merged > 32'(MAX_WIDTH)))
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_RANGE;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                width_next = asm_merged[DIM_W-1:0];
                            end
                        end
                        else if (cur_pos == POS_HEIGHT_LAST)
                        begin
                            if ((asm_merged == '0) || (asm_merged > 32'(MAX_HEIGHT)))
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_RANGE;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                height_next = asm_merged[DIM_W-1:0];
                                if (cur_start == HEADER_END)
                                begin
                                    phase_next = PH_PIXEL;
                                    pos_next   = cur_pos;
                                end
                                else
                                begin
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (skip_done)
                    begin
                        phase_next = PH_PIXEL;
                    end
                    else
                    begin
                        pos_next = cur_pos + 32'd1;
                    end
                end
                PH_PIXEL:
                begin
                    case (cur_chan)
                        CH_BLUE:
                        begin
                            blue_next = data_byte;
                            chan_next = CH_GREEN;
                        end
                        CH_GREEN:
                        begin
                            green_next = data_byte;
                            chan_next  = CH_RED;
                        end
                        default:
                        begin
                            chan_next      = CH_BLUE;
                            res.valid      = 1'b1;
                            res.red        = data_byte;
                            res.green      = cur_green;
                            res.blue       = cur_blue;
                            res.alpha      = key_hit ? ALPHA_CLEAR : ALPHA_OPAQUE;
                            res.last_pixel = last_col && last_row;
                            res.status     = ST_OK;
                            if (last_col && last_row)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (last_col)
                            begin
                                col_next = '0;
                                row_next = cur_row + DIM_W'(1);
                                // rows of 3*w bytes need w mod 4 bytes of fill
                                pad_next = cur_width[1:0];
                                if (cur_width[1:0] != 2'd0)
                                begin
                                    phase_next = PH_PAD;
                                end
                            end
                            else
                            begin
                                col_next = cur_col + DIM_W'(1);
                            end
                        end
                    endcase
                end
                PH_PAD:
                begin
                    pad_next = pad_dec;
                    if (pad_dec == 2'd0)
                    begin
                        phase_next = PH_PIXEL;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            asm_reg    <= '0;
            start_reg  <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            chan_reg   <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            pad_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            asm_reg    <= asm_next;
            start_reg  <= start_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            chan_reg   <= chan_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pad_reg    <= pad_next;
        end
    end

endmodule

// ===== hw/rtl/bmp24_pixel_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// bmp24_pixel_stream_decoder
// takes a 24-bit bmp file byte by byte and emits rgba pixels or an error
// ----------------------------------------------------------------------------
// each byte is registered at the input, its result in the result register
// throughput: one byte per cycle, set by the combinational parser step;
// input stalls only while a result waits and the input register is full
// reset: asynchronous, active low; clears config, parse state and both
// pipeline valid flags; the first byte after reset is taken as byte 0
// ----------------------------------------------------------------------------
module bmp24_pixel_stream_decoder
    import bmpd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = bmpd_pkg::MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       start_of_file,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic [7:0] alpha,
    output logic       last_pixel,
    output logic [1:0] status
);

    key_cfg_t    cfg_reg;
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        sof_reg;
    logic        out_valid_reg;
    pix_result_t out_reg;
    pix_result_t res;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_RGBA_MODE:  cfg_reg.rgba_mode  <= cfg_wdata[0];
                CFG_KEY_ENABLE: cfg_reg.key_enable <= cfg_wdata[0];
                CFG_KEY_RED:    cfg_reg.key_red    <= cfg_wdata;
                CFG_KEY_GREEN:  cfg_reg.key_green  <= cfg_wdata;
                CFG_KEY_BLUE:   cfg_reg.key_blue   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            sof_reg  <= start_of_file;
        end
    end

    bmpd_parser #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (byte_reg),
        .start_of_file (sof_reg),
        .cfg           (cfg_reg),
        .res           (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = out_reg.red;
    assign green      = out_reg.green;
    assign blue       = out_reg.blue;
    assign alpha      = out_reg.alpha;
    assign last_pixel = out_reg.last_pixel;
    assign status     = out_reg.status;

endmodule
